@@ hdl/crc8_stuffed_packet_framer_top_assert.svh @@
// ----------------------------------------------------------------------------
// Framer assertion macros
// Concurrent assertion shorthands shared by the framer checkers.
// ----------------------------------------------------------------------------
`ifndef CRC8_STUFFED_PACKET_FRAMER_TOP_ASSERT_SVH
`define CRC8_STUFFED_PACKET_FRAMER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSPF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSPF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/cspf_pkg.sv @@
// ----------------------------------------------------------------------------
// Packet framer package
// Op codes, framing bytes and the CRC-8 byte update shared by the framer.
// ----------------------------------------------------------------------------
package cspf_pkg;

    localparam int MAX_PAYLOAD_DEF = 512;
    localparam int BUF_DEPTH       = 8;
    localparam int CNT_W           = $clog2(BUF_DEPTH + 1);

    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    localparam logic [7:0] SYNC_HI  = 8'hAA;
    localparam logic [7:0] SYNC_LO  = 8'hFF;
    localparam logic [7:0] END_MARK = 8'hFD;
    localparam logic [7:0] ESC_MARK = 8'hFE;
    localparam logic [7:0] RAW_FF   = 8'hFF;
    localparam logic [7:0] RAW_FE   = 8'hFE;
    localparam logic [7:0] RAW_FD   = 8'hFD;
    localparam logic [7:0] ESC_FF   = 8'h01;
    localparam logic [7:0] ESC_FE   = 8'h00;
    localparam logic [7:0] ESC_FD   = 8'h02;
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_INIT = 8'h00;

    // MSB-first CRC-8, no reflection, no final XOR
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hdl/crc8_stuffed_packet_framer_top.sv @@
// ----------------------------------------------------------------------------
// CRC-8 byte-stuffed packet framer
// Turns start and payload transactions into a framed, escaped byte stream.
// ----------------------------------------------------------------------------
// Channel  | Dir | tdata                                   | tuser      | tlast
// s_axis   | in  | seq_number, payload_len, data_byte      | op         | -
// m_axis   | out | frame_byte                              | frame_end  | run_last
//
// One input transaction is expanded into a byte buffer of up to eight bytes;
// the buffer drains one byte per cycle on the output while m_tready is high.
// A transaction is taken when the buffer is empty or its last byte leaves in
// the same cycle. Output stalls hold the buffer and block input.
// Reset clears the packet state, the CRC and the buffer count.
// ----------------------------------------------------------------------------
module crc8_stuffed_packet_framer_top #(
    parameter int MAX_PAYLOAD = cspf_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [15:0] seq_number, [25:16] payload_len,
                                   // [33:26] data_byte, [39:34] zero
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] frame_byte
    output logic        m_tlast,   // run_last
    output logic        m_tuser    // [0] frame_end
);

    localparam int CW = cspf_pkg::CNT_W;
    localparam int BD = cspf_pkg::BUF_DEPTH;

    logic          open_reg, open_next;
    logic [9:0]    rem_reg, rem_next;
    logic [7:0]    crc_reg, crc_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          close_reg, close_next;
    logic [7:0]    byte_reg  [BD];
    logic [7:0]    byte_next [BD];

    logic          accept, pop;
    logic          op;
    logic [15:0]   seq;
    logic [9:0]    len, len_sat;
    logic [7:0]    db;
    logic [7:0]    hcrc, pcrc, esc_code;
    logic          esc, last_byte;
    logic [7:0]    gen [BD];
    logic [CW-1:0] gen_cnt;
    logic          gen_close;

    assign op  = s_tuser;
    assign seq = s_tdata[15:0];
    assign len = s_tdata[25:16];
    assign db  = s_tdata[33:26];

    assign m_tvalid = (cnt_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == '0) || ((cnt_reg == CW'(1)) && m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tdata  = byte_reg[0];
    assign m_tlast  = (cnt_reg == CW'(1));
    assign m_tuser  = close_reg && (cnt_reg == CW'(1));

    always_comb
    begin
        if ({7'd0, len} > 17'(MAX_PAYLOAD))
        begin
            len_sat = 10'(MAX_PAYLOAD);
        end
        else
        begin
            len_sat = len;
        end
        hcrc = cspf_pkg::crc8_update(cspf_pkg::CRC_INIT, seq[15:8]);
        hcrc = cspf_pkg::crc8_update(hcrc, seq[7:0]);
        hcrc = cspf_pkg::crc8_update(hcrc, {6'd0, len_sat[9:8]});
        hcrc = cspf_pkg::crc8_update(hcrc, len_sat[7:0]);
        pcrc = cspf_pkg::crc8_update(crc_reg, db);

        unique case (db)
            cspf_pkg::RAW_FF:
            begin
                esc      = 1'b1;
                esc_code = cspf_pkg::ESC_FF;
            end
            cspf_pkg::RAW_FE:
            begin
                esc      = 1'b1;
                esc_code = cspf_pkg::ESC_FE;
            end
            cspf_pkg::RAW_FD:
            begin
                esc      = 1'b1;
                esc_code = cspf_pkg::ESC_FD;
            end
            default:
            begin
                esc      = 1'b0;
                esc_code = db;
            end
        endcase
        last_byte = (rem_reg == 10'd1);

        for (int i = 0; i < BD; i++)
        begin
            gen[i] = 8'h00;
        end
        gen_cnt   = '0;
        gen_close = 1'b0;
        open_next = open_reg;
        rem_next  = rem_reg;
        crc_next  = crc_reg;

        if (op == cspf_pkg::OP_START)
        begin
            // a new start abandons whatever packet is open
            gen[0]    = cspf_pkg::SYNC_HI;
            gen[1]    = cspf_pkg::SYNC_LO;
            gen[2]    = seq[15:8];
            gen[3]    = seq[7:0];
            gen[4]    = {6'd0, len_sat[9:8]};
            gen[5]    = len_sat[7:0];
            gen[6]    = cspf_pkg::END_MARK;
            gen[7]    = hcrc;
            crc_next  = hcrc;
            rem_next  = len_sat;
            open_next = 1'b1;
            gen_cnt   = CW'(6);
            if (len_sat == 10'd0)
            begin
                gen_cnt   = CW'(8);
                gen_close = 1'b1;
                open_next = 1'b0;
            end
        end
        else if (open_reg && (rem_reg != 10'd0))
        begin
            crc_next  = pcrc;
            rem_next  = rem_reg - 10'd1;
            gen_close = last_byte;
            if (esc)
            begin
                gen[0] = cspf_pkg::ESC_MARK;
                gen[1] = esc_code;
                gen[2] = cspf_pkg::END_MARK;
                gen[3] = pcrc;
            end
            else
            begin
                gen[0] = db;
                gen[1] = cspf_pkg::END_MARK;
                gen[2] = pcrc;
            end
            gen_cnt = CW'({1'b0, esc} + 2'd1) + (last_byte ? CW'(2) : CW'(0));
            if (last_byte)
            begin
                open_next = 1'b0;
                rem_next  = 10'd0;
            end
        end
        // payload with no packet open: drop, no bytes
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        close_next = close_reg;
        for (int i = 0; i < BD; i++)
        begin
            byte_next[i] = byte_reg[i];
        end
        if (accept)
        begin
            cnt_next   = gen_cnt;
            close_next = gen_close;
            for (int i = 0; i < BD; i++)
            begin
                byte_next[i] = gen[i];
            end
        end
        else if (pop)
        begin
            // advance the buffer by one byte
            cnt_next = cnt_reg - CW'(1);
            for (int i = 0; i < BD - 1; i++)
            begin
                byte_next[i] = byte_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            rem_reg   <= 10'd0;
            crc_reg   <= cspf_pkg::CRC_INIT;
            cnt_reg   <= '0;
            close_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                open_reg <= open_next;
                rem_reg  <= rem_next;
                crc_reg  <= crc_next;
            end
            cnt_reg   <= cnt_next;
            close_reg <= close_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < BD; i++)
        begin
            byte_reg[i] <= byte_next[i];
        end
    end

endmodule

@@ hdl/cspf_checker.sv @@
// ----------------------------------------------------------------------------
// Packet framer port checker
// Watches the framer ports for ordering and handshake slips.
// ----------------------------------------------------------------------------
`include "crc8_stuffed_packet_framer_top_assert.svh"

module cspf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    logic       end_beat;
    logic       run_busy;
    logic       start_fire;
    logic       sync_out;
    logic       out_stall;
    logic [9:0] m_beat;

    assign end_beat   = m_tvalid && m_tuser;
    assign run_busy   = m_tvalid && !m_tlast;
    assign start_fire = s_tvalid && s_tready && (s_tuser == cspf_pkg::OP_START);
    assign sync_out   = m_tvalid && (m_tdata == cspf_pkg::SYNC_HI);
    assign out_stall  = m_tvalid && !m_tready;
    assign m_beat     = {m_tvalid, m_tlast, m_tdata};

    // the CRC byte always closes the run of its transaction
    `CSPF_ASSERT_IMP(a_end_is_last, clk, rst_n, end_beat, m_tlast, "frame_end without run_last")

    // no new transaction while more than one byte is pending
    `CSPF_ASSERT_IMP(a_busy_block, clk, rst_n, run_busy, !s_tready, "ready while run pending")

    // a start transaction is followed by the first sync byte
    `CSPF_ASSERT_NXT(a_start_sync, clk, rst_n, start_fire, sync_out, "no sync after start")

    // hold a stalled output byte
    `CSPF_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, $stable(m_beat), "stalled output changed")

endmodule

bind crc8_stuffed_packet_framer_top cspf_checker u_cspf_checker (.*);

@@ verif/framer_stream_checker.sv @@
// ----------------------------------------------------------------------------
// Packet framer stream checker
// Watches both stream channels of the framer, predicts the framed byte stream
// from every accepted input transaction and compares each output transaction
// field by field against the oldest predicted byte.
// ----------------------------------------------------------------------------
module framer_stream_checker
    import cspf_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    input  logic        m_tuser,
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       run_last;
        logic       frame_end;
    } frame_beat_t;

    frame_beat_t bytes_due [$];
    frame_beat_t step_beats [8];
    frame_beat_t want;
    int          step_n;

    // predicted framer state
    logic        pkt_open;
    logic [9:0]  remaining;
    logic [7:0]  crc;

    // bit-serial form of the MSB-first CRC-8
    function automatic logic [7:0] crc8_serial(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = acc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[7] ^ b[i];
            r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    function automatic void emit(input logic [7:0] v, input logic fend);
        step_beats[step_n].frame_byte = v;
        step_beats[step_n].run_last   = 1'b0;
        step_beats[step_n].frame_end  = fend;
        step_n++;
    endfunction

    function automatic void close_frame();
        emit(END_MARK, 1'b0);
        emit(crc, 1'b1);
        pkt_open  = 1'b0;
        remaining = 10'd0;
    endfunction

    task automatic predict_frame(input logic op, input logic [15:0] seq,
                                 input logic [9:0] len_in, input logic [7:0] data);
        logic [9:0] len;
        step_n = 0;
        if (op == OP_START)
        begin
            // saturate the length; header and CRC carry the clipped value
            len = (len_in > MAX_PAYLOAD) ? 10'(MAX_PAYLOAD) : len_in;
            crc = crc8_serial(CRC_INIT, seq[15:8]);
            crc = crc8_serial(crc, seq[7:0]);
            crc = crc8_serial(crc, {6'b0, len[9:8]});
            crc = crc8_serial(crc, len[7:0]);
            emit(SYNC_HI, 1'b0);
            emit(SYNC_LO, 1'b0);
            emit(seq[15:8], 1'b0);
            emit(seq[7:0], 1'b0);
            emit({6'b0, len[9:8]}, 1'b0);
            emit(len[7:0], 1'b0);
            pkt_open  = 1'b1;
            remaining = len;
            if (remaining == 10'd0)
            begin
                close_frame();
            end
        end
        else if (pkt_open && remaining != 10'd0)
        begin
            crc = crc8_serial(crc, data);
            case (data)
                RAW_FF:
                begin
                    emit(ESC_MARK, 1'b0);
                    emit(ESC_FF, 1'b0);
                end
                RAW_FE:
                begin
                    emit(ESC_MARK, 1'b0);
                    emit(ESC_FE, 1'b0);
                end
                RAW_FD:
                begin
                    emit(ESC_MARK, 1'b0);
                    emit(ESC_FD, 1'b0);
                end
                default:
                begin
                    emit(data, 1'b0);
                end
            endcase
            remaining = remaining - 10'd1;
            if (remaining == 10'd0)
            begin
                close_frame();
            end
        end
        // a payload byte with no packet open is dropped without output
        if (step_n > 0)
        begin
            step_beats[step_n - 1].run_last = 1'b1;
        end
        for (int i = 0; i < step_n; i++)
        begin
            bytes_due = {bytes_due, step_beats[i]};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_due.delete();
            pkt_open   = 1'b0;
            remaining  = 10'd0;
            crc        = CRC_INIT;
            mismatches = 0;
            pending   <= 0;
        end
        else
        begin
            // check the output side first: a byte never leaves at the edge
            // where the transaction that causes it goes in
            if (m_tvalid && m_tready)
            begin
                if (bytes_due.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("%0t checker: unexpected byte %02h last %b end %b",
                                 $time, m_tdata, m_tlast, m_tuser);
                    end
                    mismatches++;
                end
                else
                begin
                    want = bytes_due.pop_front();
                    if (m_tdata !== want.frame_byte || m_tlast !== want.run_last ||
                        m_tuser !== want.frame_end)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t checker: got byte %02h last %b end %b, want %02h %b %b",
                                     $time, m_tdata, m_tlast, m_tuser,
                                     want.frame_byte, want.run_last, want.frame_end);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_frame(s_tuser, s_tdata[15:0], s_tdata[25:16], s_tdata[33:26]);
            end
            pending <= bytes_due.size();
        end
    end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// Packet framer testbench
// Drives start and payload transactions into the framer, first a directed
// set (stray bytes, zero length, escapes, abandoned and saturated packets),
// then random packets with noise, random idling on both channels, a long
// output hold-off and a full drain pause. The checker judges every byte.
// ----------------------------------------------------------------------------
module tb;
    import cspf_pkg::*;

    localparam int MAX_PAYLOAD  = MAX_PAYLOAD_DEF;
    localparam int RANDOM_ITEMS = 300;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_LIMIT   = 5000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        s_tuser  = OP_START;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    logic        quiet    = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int          mismatches;
    int          pending;
    int          idle_cycles = 0;

    crc8_stuffed_packet_framer_top #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    framer_stream_checker #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // output side: random back-pressure, one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= quiet || ($urandom_range(99) >= 17);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // offer one transaction and hold it until it is taken
    task automatic send_item(input logic op, input logic [15:0] seq,
                             input logic [9:0] plen, input logic [7:0] data);
        while (!quiet && $urandom_range(99) < 17)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tuser  <= op;
        s_tdata  <= {6'b0, data, plen, seq};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [7:0] pick_payload();
        if ($urandom_range(3) == 0)
        begin
            return RAW_FD + 8'($urandom_range(2));
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
    endtask

    initial
    begin
        int         sent;
        int         pkt_cnt;
        int         plen;
        int         nsend;
        int         sel;

        sent    = 0;
        pkt_cnt = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray byte with no packet open, then a zero-length packet
        send_item(OP_PAYLOAD, 16'hFFFF, 10'h3FF, 8'h55);
        send_item(OP_START, 16'h0000, 10'd0, 8'hFF);
        // all three escaped bytes, last one closes the frame
        send_item(OP_START, 16'hFFFF, 10'd3, 8'h00);
        send_item(OP_PAYLOAD, 16'h0000, 10'd0, RAW_FF);
        send_item(OP_PAYLOAD, 16'h0000, 10'd0, RAW_FE);
        send_item(OP_PAYLOAD, 16'h0000, 10'd0, RAW_FD);
        // abandon an open packet, then an oversized length that saturates
        send_item(OP_START, 16'hA5A5, 10'd4, 8'h00);
        send_item(OP_PAYLOAD, 16'h0000, 10'd0, 8'h7F);
        send_item(OP_START, 16'h5A5A, 10'h3FF, 8'h00);
        send_item(OP_PAYLOAD, 16'hFFFF, 10'h3FF, 8'h00);
        send_item(OP_PAYLOAD, 16'h0000, 10'd0, 8'h80);
        send_item(OP_START, 16'h00FF, 10'd2, 8'hFF);
        send_item(OP_PAYLOAD, 16'h0000, 10'd0, 8'hFC);
        send_item(OP_PAYLOAD, 16'h0000, 10'd0, 8'h01);
        send_item(OP_PAYLOAD, 16'h0000, 10'd0, 8'hAA);
        send_item(OP_START, 16'h1234, 10'd1, 8'h00);
        send_item(OP_PAYLOAD, 16'h0000, 10'd0, RAW_FF);

        while (sent < RANDOM_ITEMS)
        begin
            pkt_cnt++;
            quiet <= (pkt_cnt >= 3 && pkt_cnt < 14);
            if (pkt_cnt == 20)
            begin
                hold_req <= 1'b1;
            end
            if (pkt_cnt == 28)
            begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            if ($urandom_range(99) < 82)
            begin
                sel = $urandom_range(99);
                if (sel < 80)
                begin
                    plen = $urandom_range(12);
                end
                else if (sel < 95)
                begin
                    plen = $urandom_range(13, 40);
                end
                else
                begin
                    plen = $urandom_range(MAX_PAYLOAD + 1, 1023);
                end
                nsend = plen;
                if (plen > 40)
                begin
                    nsend = $urandom_range(1, 8);
                end
                else if (plen > 0 && $urandom_range(99) < 10)
                begin
                    // cut the packet short; the next start abandons it
                    nsend = $urandom_range(plen - 1);
                end
                send_item(OP_START, 16'($urandom), 10'(plen), 8'($urandom));
                sent++;
                for (int i = 0; i < nsend; i++)
                begin
                    send_item(OP_PAYLOAD, 16'($urandom), 10'($urandom), pick_payload());
                    sent++;
                end
                if ($urandom_range(99) < 15)
                begin
                    send_item(OP_PAYLOAD, 16'($urandom), 10'($urandom), pick_payload());
                    sent++;
                end
            end
            else
            begin
                send_item(1'($urandom_range(1)), 16'($urandom), 10'($urandom),
                          8'($urandom));
                sent++;
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
